/* rtl/til_pkg.sv */
// Package for the trie insert/lookup unit: state machine type, request codes
// and the fixed letter field width. No dependencies.
package til_pkg;

	// Fixed width of the letter field of a request
	localparam int LETTER_W = 5;

	// Request operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,   // sweep of the node pool after reset
		ST_IDLE,    // waiting for a request
		ST_WALK,    // row read back, child lookup / allocation
		ST_LOOKUP   // word-end mark read back for a query
	} st_t;

endpackage

/* rtl/til_if.sv */
// Handshake channels of the trie insert/lookup unit: request and response.
// Depends on til_pkg.
interface til_req_if import til_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [LETTER_W-1:0] letter;
	logic                last;

	modport source (output valid, output operation, output letter, output last, input ready);
	modport sink   (input valid, input operation, input letter, input last, output ready);
endinterface

interface til_rsp_if #(
	parameter int COUNT_BITS = 16
) ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic                  pool_full;
	logic [COUNT_BITS-1:0] match_count;

	modport source (output valid, output found, output pool_full, output match_count,
		input ready);
	modport sink   (input valid, input found, input pool_full, input match_count,
		output ready);
endinterface

/* rtl/trie_insert_and_lookup_unit.sv */
// Letter-serial trie dictionary: insert and query of words over a node pool.
// Depends on til_pkg and the til_req_if / til_rsp_if channels.
//
// One request carries one letter. The node's child row is read from the child memory
// in the accept cycle, and the next cycle picks the child, allocates a new node if
// needed and writes the row back when it allocates. The last letter of a query adds a
// lookup state, since the word-end mark of the reached node is read from a second memory
// once the node is known. A response is sent on every last letter; the next request is
// taken once the response register is empty or being drained. After reset both
// memories are cleared one row per cycle, and no request is taken until the sweep is
// done. The response channel's COUNT_BITS must match this module's COUNT_BITS.
module trie_insert_and_lookup_unit import til_pkg::*; #(
	parameter int MAX_NODES  = 4096,
	parameter int ALPHABET   = 26,
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	til_req_if.sink    req,
	til_rsp_if.source  rsp
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int USED_W = $clog2(MAX_NODES + 1);
	localparam int LIDX_W = $clog2(ALPHABET);

	typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

	// Node pool memories
	row_t child_mem [MAX_NODES];
	logic mark_mem  [MAX_NODES];

	// Control state
	st_t                   state_q, state_d;
	logic [NODE_W-1:0]     clr_q;
	logic [NODE_W-1:0]     cur_q;
	logic [USED_W-1:0]     used_q;
	logic                  broken_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic                  full_q;

	// Request held for the walk cycle, memory read data
	logic                  op_s1;
	logic [LETTER_W-1:0]   letter_s1;
	logic                  last_s1;
	row_t                  row_s1;
	logic                  mark_s1;

	// Walk datapath
	logic                  letter_ok;
	logic [LIDX_W-1:0]     lidx;
	logic [NODE_W-1:0]     child;
	logic                  walk;
	logic                  miss;
	logic                  pool_out;
	logic                  alloc_do;
	logic                  broken_n;
	logic [NODE_W-1:0]     node_n;
	row_t                  upd_row;
	logic                  lookup_hit;

	// Sequencer outputs
	logic                  accept;
	logic                  row_re;
	logic                  row_we;
	logic [NODE_W-1:0]     row_wa;
	row_t                  row_wd;
	logic                  mark_re;
	logic                  mark_we;
	logic [NODE_W-1:0]     mark_wa;
	logic                  mark_wd;
	logic                  produce;
	logic                  res_found;
	logic                  res_full;

	// Child selection and allocation for the current letter
	always_comb begin
		letter_ok = 32'(letter_s1) < ALPHABET;
		lidx      = letter_ok ? LIDX_W'(letter_s1) : '0;
		child     = row_s1[lidx];
		walk      = !broken_q && letter_ok;
		miss      = walk && (child == '0);
		pool_out  = used_q == USED_W'(MAX_NODES);
		alloc_do  = miss && (op_s1 == OP_INSERT) && !pool_out;
		broken_n  = broken_q || (miss && !alloc_do);
		node_n    = cur_q;
		if (walk && child != '0) begin
			node_n = child;
		end else if (alloc_do) begin
			node_n = used_q[NODE_W-1:0];
		end
		upd_row = row_s1;
		if (alloc_do) begin
			upd_row[lidx] = used_q[NODE_W-1:0];
		end
		lookup_hit = !broken_q && mark_s1;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == NODE_W'(MAX_NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (last_s1 && op_s1 == OP_QUERY) state_d = ST_LOOKUP;
				else state_d = ST_IDLE;
			end
			ST_LOOKUP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory strobes and response
	always_comb begin
		req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
		accept    = req.valid && req.ready;
		row_re    = accept;
		row_we    = 1'b0;
		row_wa    = cur_q;
		row_wd    = upd_row;
		mark_re   = 1'b0;
		mark_we   = 1'b0;
		mark_wa   = node_n;
		mark_wd   = 1'b1;
		produce   = 1'b0;
		res_found = 1'b0;
		res_full  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				row_we  = 1'b1;
				row_wa  = clr_q;
				row_wd  = '0;
				mark_we = 1'b1;
				mark_wa = clr_q;
				mark_wd = 1'b0;
			end
			ST_WALK: begin
				row_we = alloc_do;
				if (last_s1 && op_s1 == OP_QUERY) begin
					mark_re = 1'b1;
				end else if (last_s1) begin
					mark_we  = !broken_n;
					produce  = 1'b1;
					res_full = broken_n;
				end
			end
			ST_LOOKUP: begin
				produce   = 1'b1;
				res_found = lookup_hit;
			end
			default: ;
		endcase
	end

	// Node pool memories, registered read
	always_ff @(posedge clk) begin
		if (row_we) child_mem[row_wa] <= row_wd;
		if (row_re) row_s1 <= child_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (mark_re) mark_s1 <= mark_mem[node_n];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= req.operation;
			letter_s1 <= req.letter;
			last_s1   <= req.last;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			used_q      <= USED_W'(1);
			broken_q    <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + NODE_W'(1);
			if (alloc_do && state_q == ST_WALK) used_q <= used_q + USED_W'(1);

			// word walk position, back to the root at the end of a word
			if (state_q == ST_WALK) begin
				if (last_s1 && op_s1 == OP_INSERT) begin
					cur_q    <= '0;
					broken_q <= 1'b0;
				end else begin
					cur_q    <= node_n;
					broken_q <= broken_n;
				end
			end else if (state_q == ST_LOOKUP) begin
				cur_q    <= '0;
				broken_q <= 1'b0;
				if (lookup_hit && total_q != '1) total_q <= total_q + COUNT_BITS'(1);
			end

			// response register
			if (produce) begin
				out_valid_q <= 1'b1;
				found_q     <= res_found;
				full_q      <= res_full;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Match count is stable while a response waits: it only moves when one is made
	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.pool_full   = full_q;
	assign rsp.match_count = total_q;

	// Pool count stays within bounds
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0 && used_q <= USED_W'(MAX_NODES))
		else $error("node count out of range");

	// Walk position always names an allocated node
	a_cur_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		USED_W'(cur_q) < used_q)
		else $error("current node not allocated");

	// Allocation takes exactly the next free node
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && alloc_do) |=> used_q == $past(used_q) + USED_W'(1))
		else $error("node count did not advance on allocation");

	// No response is made while an earlier one still waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_LOOKUP) |-> !out_valid_q)
		else $error("response register busy during walk");

	// Query end returns the walk to the root
	a_lookup_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |=> (cur_q == '0 && !broken_q))
		else $error("walk not reset after query end");

endmodule

/* sim/tb_trie_insert_and_lookup_unit.sv */
// Testbench for trie_insert_and_lookup_unit: letter requests are driven over
// til_req_if, responses checked against a behavioral trie held in a scoreboard.
// Depends on til_pkg, til_req_if / til_rsp_if and the unit itself.
module tb_trie_insert_and_lookup_unit;
	import til_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_NODES  = 4096;
	localparam int ALPHABET   = 26;
	localparam int COUNT_BITS = 16;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int RANDOM_LETTERS = 1400;

	typedef struct packed {
		logic                  found;
		logic                  pool_full;
		logic [COUNT_BITS-1:0] match_count;
	} answer_t;

	typedef struct {
		int                         len;
		logic [7:0][LETTER_W-1:0]   ltr;
	} word_t;

	// Behavioral trie plus the queue of answers it still owes
	class word_lookup_board;
		bit [NODE_W-1:0]     child_row [MAX_NODES*ALPHABET];
		bit                  word_end [MAX_NODES];
		bit [NODE_W:0]       nodes_used;
		bit [NODE_W-1:0]     cur_node;
		bit                  broken;
		bit [COUNT_BITS-1:0] hits;
		answer_t             pending_answers[$];
		int                  fail_count;

		function new();
			nodes_used = 1;
			cur_node   = '0;
			broken     = 1'b0;
			hits       = '0;
			fail_count = 0;
		endfunction

		// One accepted letter: walk or grow the trie, owe an answer on the last one
		function void take_letter(logic op, logic [LETTER_W-1:0] letter, logic last);
			int              slot;
			bit [NODE_W-1:0] nxt;
			answer_t         ans;
			if (!broken && int'(letter) < ALPHABET) begin
				slot = int'(cur_node) * ALPHABET + int'(letter);
				nxt  = child_row[slot];
				if (nxt == '0) begin
					if (op == OP_QUERY || nodes_used >= MAX_NODES) begin
						broken = 1'b1;
					end else begin
						nxt = nodes_used[NODE_W-1:0];
						nodes_used++;
						child_row[slot] = nxt;
					end
				end
				if (!broken)
					cur_node = nxt;
			end
			if (last) begin
				ans.found     = 1'b0;
				ans.pool_full = 1'b0;
				if (op == OP_QUERY) begin
					if (!broken && word_end[cur_node]) begin
						ans.found = 1'b1;
						if (hits != '1)
							hits++;
					end
				end else if (broken) begin
					ans.pool_full = 1'b1;
				end else begin
					word_end[cur_node] = 1'b1;
				end
				ans.match_count = hits;
				pending_answers.insert(pending_answers.size(), ans);
				cur_node = '0;
				broken   = 1'b0;
			end
		endfunction

		// One accepted response against the oldest owed answer
		function void match_answer(logic found, logic pool_full,
			logic [COUNT_BITS-1:0] match_count);
			answer_t exp;
			if (pending_answers.size() == 0) begin
				$error("response with no request pending: found %0d pool_full %0d count %0d",
					found, pool_full, match_count);
				fail_count++;
				return;
			end
			exp = pending_answers.pop_front();
			if (found !== exp.found) begin
				$error("found: expected %0d, actual %0d", exp.found, found);
				fail_count++;
			end
			if (pool_full !== exp.pool_full) begin
				$error("pool_full: expected %0d, actual %0d", exp.pool_full, pool_full);
				fail_count++;
			end
			if (match_count !== exp.match_count) begin
				$error("match_count: expected %0d, actual %0d", exp.match_count, match_count);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	til_req_if req_ch ();
	til_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_ch ();

	trie_insert_and_lookup_unit #(
		.MAX_NODES (MAX_NODES),
		.ALPHABET  (ALPHABET),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	word_lookup_board board = new();
	word_t book[$];
	int    letters_sent = 0;
	int    burst_left   = 0;
	bit    steady       = 1'b0;
	bit    hold_go      = 1'b0;

	// Clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.match_answer(rsp_ch.found, rsp_ch.pool_full, rsp_ch.match_count);
	end

	// Response ready: changing stall modes, plus one long hold-off on request
	initial begin : rsp_stall
		int  mode_left;
		int  mode;
		int  hold_left;
		int  tick;
		bit  hold_done;
		mode_left = 0;
		mode      = 0;
		hold_left = 0;
		tick      = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_go && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ((tick % 3) != 0);
				endcase
			end
		end
	end

	// Sender pacing: bursts of random length, random gaps between them
	task automatic pace();
		if (!steady) begin
			if (burst_left == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
			end
			burst_left--;
		end
	endtask

	// Offer one letter request, wait for acceptance, note it
	task automatic send_item(input logic op, input logic [LETTER_W-1:0] ltr, input logic lst);
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.letter    <= ltr;
		req_ch.last      <= lst;
		do @(posedge clk); while (!req_ch.ready);
		board.take_letter(op, ltr, lst);
		letters_sent++;
		@(negedge clk);
		pace();
	endtask

	// Stop offering until every owed response is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.pending_answers.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Mostly a small set of letters so words collide, sometimes any code
	function automatic logic [LETTER_W-1:0] pick_letter();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return LETTER_W'($urandom_range(0, 4));
		else if (r < 95)
			return LETTER_W'($urandom_range(0, ALPHABET - 1));
		return LETTER_W'($urandom_range(0, 31));
	endfunction

	// Random words: inserts, queries of known, mutated or new words, mixed words, noise
	task automatic random_words(input int goal);
		word_t w;
		int    kind;
		int    mode;
		int    k;
		logic  op;
		while (letters_sent < goal) begin
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				send_item(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			end else begin
				mode = $urandom_range(0, 99);
				if (mode >= 45 && mode < 90 && book.size() > 0 && $urandom_range(0, 99) < 60) begin
					w = book[$urandom_range(0, book.size() - 1)];
					if ($urandom_range(0, 3) == 0)
						w.ltr[$urandom_range(0, w.len - 1)] = pick_letter();
				end else begin
					w.len = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 5);
					for (k = 0; k < w.len; k++)
						w.ltr[k] = pick_letter();
				end
				if (mode < 45 && book.size() < 256)
					book.insert(book.size(), w);
				for (k = 0; k < w.len; k++) begin
					if (mode < 45)
						op = OP_INSERT;
					else if (mode < 90)
						op = OP_QUERY;
					else
						op = 1'($urandom_range(0, 1));
					send_item(op, w.ltr[k], k == w.len - 1);
				end
			end
			if (letters_sent > 600 && !hold_go)
				hold_go = 1'b1;
		end
	endtask

	// Main sequence
	initial begin : stimulus
		int k;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_INSERT;
		req_ch.letter    = '0;
		req_ch.last      = 1'b0;
		rsp_ch.ready     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: hits, misses, broken paths, skipped codes, mixed words
		send_item(OP_INSERT, 0, 1);
		send_item(OP_QUERY, 0, 1);
		send_item(OP_INSERT, 0, 0);
		send_item(OP_INSERT, 25, 1);
		send_item(OP_QUERY, 0, 0);
		send_item(OP_QUERY, 25, 1);
		send_item(OP_QUERY, 1, 1);
		send_item(OP_QUERY, 0, 0);
		send_item(OP_QUERY, 25, 0);
		send_item(OP_QUERY, 0, 1);
		send_item(OP_QUERY, 0, 0);
		send_item(OP_QUERY, 30, 0);
		send_item(OP_QUERY, 25, 1);
		// out-of-range last letter on insert marks the root itself
		send_item(OP_INSERT, 31, 1);
		send_item(OP_QUERY, 31, 1);
		send_item(OP_QUERY, 26, 1);
		send_item(OP_INSERT, 2, 0);
		send_item(OP_QUERY, 2, 1);
		// query breaks the path, insert ends the word: reported as pool full
		send_item(OP_QUERY, 3, 0);
		send_item(OP_INSERT, 4, 1);
		send_item(OP_INSERT, 0, 0);
		send_item(OP_INSERT, 25, 1);
		send_item(OP_INSERT, 16, 0);
		send_item(OP_INSERT, 15, 1);
		drain();

		// Random words, with one long response hold-off in the middle
		random_words(letters_sent + RANDOM_LETTERS);
		drain();

		// Back-to-back hits on a one-letter word
		steady = 1'b1;
		for (k = 0; k < 60; k++)
			send_item(OP_QUERY, 0, 1);
		steady = 1'b0;
		drain();

		if (board.fail_count == 0 && board.pending_answers.size() == 0)
			$display("trie_insert_and_lookup_unit test passed");
		else
			$display("trie_insert_and_lookup_unit test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("trie_insert_and_lookup_unit test failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/til_pkg.sv
rtl/til_if.sv
rtl/trie_insert_and_lookup_unit.sv
sim/tb_trie_insert_and_lookup_unit.sv
